// ===== rtl/nds_pkg.sv =====
package nds_pkg;

  // field and counter widths fixed by the pixel format and the register map
  localparam int CFG_W   = 12;
  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int ERR_W   = 13;
  localparam int PIX_W   = 16;
  localparam int IDX_W   = 2;
  localparam int CHAN_W  = 8;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 12'd480;
  localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 12'd96;
  localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 12'd96;

  typedef struct packed {
    logic [CFG_W-1:0] source_width;
    logic [CFG_W-1:0] source_height;
    logic [CFG_W-1:0] target_width;
    logic [CFG_W-1:0] target_height;
  } size_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] src_col;
    logic [POS_W-1:0] src_row;
    logic [ERR_W-1:0] col_error;
    logic [ERR_W-1:0] row_error;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             row_taken;
  } scan_state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              line_end;
    logic              frame_end;
  } rgb_out_t;

endpackage

// ===== rtl/nds_step.sv =====
module nds_step #(
  parameter int MAX_DIM = 2048
) (
  input  nds_pkg::size_cfg_t          cfg,
  input  nds_pkg::scan_state_t        state,
  input  logic [nds_pkg::PIX_W-1:0]   pixel_565,
  input  logic                        frame_start,
  output nds_pkg::scan_state_t        state_nxt,
  output logic                        emit,
  output nds_pkg::rgb_out_t           result
);
  import nds_pkg::*;

  localparam logic [DIM_W-1:0] MAX_V = DIM_W'(MAX_DIM);

  // zero reads as one, oversize clamps to the maximum
  function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] w;
    w = DIM_W'(v);
    if (v == '0) begin
      dim_of = DIM_W'(1);
    end else if (w > MAX_V) begin
      dim_of = MAX_V;
    end else begin
      dim_of = w;
    end
  endfunction

  logic [DIM_W-1:0] sw, sh, dw_raw, dh_raw, dw, dh;
  logic [DIM_W-1:0] dw_m1, dh_m1;
  scan_state_t      cur;
  logic             taken;
  logic             col_sel;
  logic [ERR_W-1:0] ce_add, ce_sat, re_add, re_sat;
  logic [4:0]       r5, b5;
  logic [5:0]       g6;

  always_comb begin
    sw     = dim_of(cfg.source_width);
    sh     = dim_of(cfg.source_height);
    dw_raw = dim_of(cfg.target_width);
    dh_raw = dim_of(cfg.target_height);
    dw     = (dw_raw > sw) ? sw : dw_raw;
    dh     = (dh_raw > sh) ? sh : dh_raw;
    dw_m1  = dw - DIM_W'(1);
    dh_m1  = dh - DIM_W'(1);

    cur = frame_start ? '0 : state;

    // row decision made on column zero and held for the row
    taken   = (cur.src_col == '0) ? (cur.row_error < dh) : cur.row_taken;
    col_sel = cur.col_error < dw;

    emit = taken && col_sel;

    r5 = pixel_565[15:11];
    g6 = pixel_565[10:5];
    b5 = pixel_565[4:0];
    result.red       = {r5, r5[4:2]};
    result.green     = {g6, g6[5:4]};
    result.blue      = {b5, b5[4:2]};
    result.line_end  = cur.out_col == dw_m1[POS_W-1:0];
    result.frame_end = result.line_end && (cur.out_row == dh_m1[POS_W-1:0]);

    // column error step with saturation at zero
    ce_add = col_sel ? ERR_W'(cur.col_error + sw) : cur.col_error;
    ce_sat = (ce_add >= dw) ? ERR_W'(ce_add - dw) : '0;

    re_add = taken ? ERR_W'(cur.row_error + sh) : cur.row_error;
    re_sat = (re_add >= dh) ? ERR_W'(re_add - dh) : '0;

    state_nxt           = cur;
    state_nxt.row_taken = taken;
    if (DIM_W'(cur.src_col) >= sw - DIM_W'(1)) begin
      // end of source line
      state_nxt.src_col   = '0;
      state_nxt.col_error = '0;
      state_nxt.out_col   = '0;
      if (DIM_W'(cur.src_row) >= sh - DIM_W'(1)) begin
        state_nxt = '0;
      end else begin
        if (taken) begin
          state_nxt.out_row = cur.out_row + POS_W'(1);
        end
        state_nxt.row_error = re_sat;
        state_nxt.src_row   = cur.src_row + POS_W'(1);
      end
    end else begin
      state_nxt.src_col   = cur.src_col + POS_W'(1);
      state_nxt.col_error = ce_sat;
      if (col_sel) begin
        state_nxt.out_col = cur.out_col + POS_W'(1);
      end
    end
  end

endmodule

// ===== rtl/nearest_downscale_rgb565_to_rgb888.sv =====
// channel | direction | tdata                          | tuser        | tlast
// in_     | slave     | pixel_565                      | frame_start  | -
// out_    | master    | red, green, blue (low to high) | frame_end    | line_end
// cfg_    | write     | cfg_wdata at cfg_index when cfg_we, no read-back
//
// one pixel per cycle sustained while out_ does not stall; a pixel passes an input register, then the
// selection counters and channel widening, which are combinational, then the result register
// stalls on out_tready hold the result register and a full input register; in_tready follows the result register
// rst_n is synchronous, active low; it clears sizes to 640x480 -> 96x96 and counters
module nearest_downscale_rgb565_to_rgb888 #(
  parameter int MAX_DIM = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [nds_pkg::IDX_W-1:0]    cfg_index,
  input  logic [nds_pkg::CFG_W-1:0]    cfg_wdata,
  // source pixels
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,   // [15:0] pixel_565
  input  logic                         in_tuser,   // [0] frame_start
  // output pixels
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [23:0]                  out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                         out_tlast,  // line_end
  output logic                         out_tuser   // [0] frame_end
);
  import nds_pkg::*;

  size_cfg_t          cfg_r;
  scan_state_t        state_r;
  scan_state_t        state_nxt;

  // input register
  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic               s1_start_r;

  // result register
  logic               out_valid_r;
  rgb_out_t           out_pix_r;

  logic               emit;
  rgb_out_t           result;
  logic               s1_go;
  logic               in_take;

  // the input register moves on whenever the result register is free or draining
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_take   = in_tvalid && in_tready;

  nds_step #(
    .MAX_DIM (MAX_DIM)
  ) u_step (
    .cfg         (cfg_r),
    .state       (state_r),
    .pixel_565   (s1_pix_r),
    .frame_start (s1_start_r),
    .state_nxt   (state_nxt),
    .emit        (emit),
    .result      (result)
  );

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= RST_SRC_WIDTH;
      cfg_r.source_height <= RST_SRC_HEIGHT;
      cfg_r.target_width  <= RST_DST_WIDTH;
      cfg_r.target_height <= RST_DST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  cfg_r.source_width  <= cfg_wdata;
        REG_SRC_HEIGHT: cfg_r.source_height <= cfg_wdata;
        REG_DST_WIDTH:  cfg_r.target_width  <= cfg_wdata;
        REG_DST_HEIGHT: cfg_r.target_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control: valid flags and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_go) begin
        // counters advance for every source pixel, selected or not
        state_r     <= state_nxt;
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix_r   <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (s1_go && emit) begin
      out_pix_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r.blue, out_pix_r.green, out_pix_r.red};
  assign out_tlast  = out_pix_r.line_end;
  assign out_tuser  = out_pix_r.frame_end;

endmodule
